// ----- rtl/core/toroidal_life_grid_engine_assert.svh -----
// Assertion macros used by the toroidal life grid engine port checker.
`ifndef TOROIDAL_LIFE_GRID_ENGINE_ASSERT_SVH
`define TOROIDAL_LIFE_GRID_ENGINE_ASSERT_SVH

// Checked only while out of reset.
`define TLGE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define TLGE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/tlge_pkg.sv -----
// Shared types and constants of the toroidal life grid engine.
`default_nettype none

package tlge_pkg;

    localparam int DEF_GRID_ROWS = 64;
    localparam int DEF_GRID_COLS = 64;

    // Width of the row and column fields of an input word.
    localparam int IDX_W = 6;

    // Neighbor count width and the B3/S23 rule.
    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] LIFE_BIRTH   = NBR_W'(3);
    localparam logic [NBR_W-1:0] LIFE_SURVIVE = NBR_W'(2);

    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic item_load;
        logic res_clr;
        logic rd_seq;
        logic rd_item;
        logic shift;
        logic shift_row0;
        logic save_row0;
        logic step_wr;
        logic clr_wr;
        logic tog_wr;
        logic rd_take;
        logic out_load;
    } tlge_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } tlge_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/tlge_ctrl.sv -----
// Controller state machine: command decode, row sequencing and clear sweeps.
`default_nettype none

module tlge_ctrl import tlge_pkg::*; #(
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire logic [1:0]                   s_opcode,
    output logic                              s_ready,
    input  wire tlge_status_t                 status,
    output tlge_cmd_t                         cmd,
    output logic [$clog2(GRID_ROWS)-1:0]      rd_row,
    output logic [$clog2(GRID_ROWS)-1:0]      wr_row
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int KW = $clog2(GRID_ROWS + 3);

    localparam logic [KW-1:0] K_LAST_RD  = KW'(GRID_ROWS);
    localparam logic [KW-1:0] K_ROW0     = KW'(GRID_ROWS + 1);
    localparam logic [KW-1:0] K_STEP_END = KW'(GRID_ROWS + 2);
    localparam logic [KW-1:0] K_CLR_END  = KW'(GRID_ROWS - 1);
    localparam logic [RW-1:0] ROW_LAST   = RW'(GRID_ROWS - 1);

    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_STEP   = 9'b000000100,
        ST_CLEAR  = 9'b000001000,
        ST_TOG_RD = 9'b000010000,
        ST_TOG_WR = 9'b000100000,
        ST_RD_RD  = 9'b001000000,
        ST_RD_OUT = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [KW-1:0]   k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Step read order: last row, then rows 0 .. last; the wrap row 0 comes
    // from the saved copy at the end.
    always_comb begin
        if (k_reg == '0 || k_reg == K_LAST_RD) begin
            rd_row = ROW_LAST;
        end else begin
            rd_row = RW'(k_reg - KW'(1));
        end
        if (state_reg == ST_STEP) begin
            wr_row = RW'(k_reg - KW'(2));
        end else begin
            wr_row = RW'(k_reg);
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_INIT: begin
                cmd.clr_wr = 1'b1;
                if (k_reg == K_CLR_END) begin
                    state_next = ST_IDLE;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    cmd.res_clr   = 1'b1;
                    k_next        = '0;
                    unique case (opcode_t'(s_opcode))
                        OP_STEP:   state_next = ST_STEP;
                        OP_TOGGLE: state_next = ST_TOG_RD;
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_READ:   state_next = ST_RD_RD;
                    endcase
                end
            end
            ST_STEP: begin
                cmd.rd_seq     = (k_reg <= K_LAST_RD);
                cmd.shift      = (k_reg <= K_ROW0);
                cmd.shift_row0 = (k_reg == K_ROW0);
                cmd.save_row0  = (k_reg == KW'(1));
                cmd.step_wr    = (k_reg >= KW'(2)) && (k_reg <= K_ROW0);
                // K_STEP_END adds a spare step past the last issue so the final row can land.
                if (k_reg == K_STEP_END) begin
                    state_next = ST_DONE;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (k_reg == K_CLR_END) begin
                    state_next = ST_DONE;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_TOG_RD: begin
                cmd.rd_item = 1'b1;
                state_next  = ST_TOG_WR;
            end
            ST_TOG_WR: begin
                cmd.tog_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_RD_RD: begin
                cmd.rd_item = 1'b1;
                state_next  = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                cmd.rd_take = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/tlge_datapath.sv -----
// Datapath: row memory, three-row window, next-generation logic, result register.
`default_nettype none

module tlge_datapath import tlge_pkg::*; #(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [IDX_W-1:0]             s_row_index,
    input  wire logic [IDX_W-1:0]             s_column_index,
    input  wire tlge_cmd_t                    cmd,
    input  wire logic [$clog2(GRID_ROWS)-1:0] rd_row,
    input  wire logic [$clog2(GRID_ROWS)-1:0] wr_row,
    output tlge_status_t                      status,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_cell_value
);

    localparam int RW  = $clog2(GRID_ROWS);
    localparam int CW  = $clog2(GRID_COLS);
    // One spare bit so the grid size itself fits in the bound compare.
    localparam int ARW = ((RW > IDX_W) ? RW : IDX_W) + 1;
    localparam int ACW = ((CW > IDX_W) ? CW : IDX_W) + 1;

    // One word per grid row.
    logic [GRID_COLS-1:0] mem [GRID_ROWS];

    logic [GRID_COLS-1:0] rdata_reg;
    logic [GRID_COLS-1:0] win_up_reg, win_mid_reg, win_dn_reg, row0_reg;
    logic [GRID_COLS-1:0] step_row;
    logic [GRID_COLS-1:0] col_mask;

    logic [IDX_W-1:0]     item_row_reg, item_col_reg;
    logic [ARW-1:0]       row_ext;
    logic [ACW-1:0]       col_ext;
    logic [RW-1:0]        row_sel;
    logic [CW-1:0]        col_sel;
    logic                 on_grid;

    logic                 s1_shift_reg, s1_row0_reg, s1_save_reg, s1_wr_reg;
    logic [RW-1:0]        s1_row_reg;
    logic                 s2_wr_reg;
    logic [RW-1:0]        s2_row_reg;

    logic                 mem_we, mem_re;
    logic [RW-1:0]        mem_waddr, mem_raddr;
    logic [GRID_COLS-1:0] mem_wdata;

    logic                 res_reg;
    logic                 m_valid_reg, m_cell_value_reg;

    // Addressed cell of the current word.
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_row_reg <= s_row_index;
            item_col_reg <= s_column_index;
        end
    end

    assign row_ext  = ARW'(item_row_reg);
    assign col_ext  = ACW'(item_col_reg);
    assign row_sel  = row_ext[RW-1:0];
    assign col_sel  = col_ext[CW-1:0];
    assign on_grid  = (row_ext < ARW'(GRID_ROWS)) && (col_ext < ACW'(GRID_COLS));
    assign col_mask = GRID_COLS'(1) << col_sel;

    // Step pipeline: issue, shift into window, write back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_shift_reg <= 1'b0;
            s1_row0_reg  <= 1'b0;
            s1_save_reg  <= 1'b0;
            s1_wr_reg    <= 1'b0;
            s2_wr_reg    <= 1'b0;
        end else begin
            s1_shift_reg <= cmd.shift;
            s1_row0_reg  <= cmd.shift_row0;
            s1_save_reg  <= cmd.save_row0;
            s1_wr_reg    <= cmd.step_wr;
            s2_wr_reg    <= s1_wr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_row_reg <= wr_row;
        s2_row_reg <= s1_row_reg;
        if (s1_shift_reg) begin
            win_up_reg  <= win_mid_reg;
            win_mid_reg <= win_dn_reg;
            win_dn_reg  <= s1_row0_reg ? row0_reg : rdata_reg;
        end
        // Hold the original row 0 for the wrap at the bottom edge.
        if (s1_save_reg) begin
            row0_reg <= rdata_reg;
        end
    end

    // Next generation of the window's middle row.
    for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
        localparam int LF = (c + GRID_COLS - 1) % GRID_COLS;
        localparam int RT = (c + 1) % GRID_COLS;
        logic [NBR_W-1:0] nbr;
        assign nbr = NBR_W'(win_up_reg[LF]) + NBR_W'(win_up_reg[c]) + NBR_W'(win_up_reg[RT])
                   + NBR_W'(win_mid_reg[LF]) + NBR_W'(win_mid_reg[RT])
                   + NBR_W'(win_dn_reg[LF]) + NBR_W'(win_dn_reg[c]) + NBR_W'(win_dn_reg[RT]);
        assign step_row[c] = (nbr == LIFE_BIRTH) || (win_mid_reg[c] && (nbr == LIFE_SURVIVE));
    end

    always_comb begin
        mem_re    = cmd.rd_seq || cmd.rd_item;
        mem_raddr = cmd.rd_item ? row_sel : rd_row;
        mem_we    = 1'b0;
        mem_waddr = s2_row_reg;
        mem_wdata = step_row;
        priority if (s2_wr_reg) begin
            mem_we = 1'b1;
        end else if (cmd.clr_wr) begin
            mem_we    = 1'b1;
            mem_waddr = wr_row;
            mem_wdata = '0;
        end else if (cmd.tog_wr && on_grid) begin
            mem_we    = 1'b1;
            mem_waddr = row_sel;
            mem_wdata = rdata_reg ^ col_mask;
        end else begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Result of the current word.
    always_ff @(posedge aclk) begin
        priority if (cmd.res_clr) begin
            res_reg <= 1'b0;
        end else if (cmd.tog_wr) begin
            res_reg <= on_grid & ~rdata_reg[col_sel];
        end else if (cmd.rd_take) begin
            res_reg <= on_grid & rdata_reg[col_sel];
        end else begin
            res_reg <= res_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_cell_value_reg <= res_reg;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_cell_value    = m_cell_value_reg;

endmodule

`default_nettype wire

// ----- rtl/core/toroidal_life_grid_engine.sv -----
// One word is in work at a time: the next is accepted only after the result of the last one
// is loaded into the output register, which waits until that register is empty or being taken.
// A step reads every grid row through the single row-memory read port, the last row twice,
// whole rows at a time, so its length follows GRID_ROWS.
// Reset (synchronous, active low) empties the output and then sweeps the row memory to
// all dead, with s_ready low until the sweep ends.
`default_nettype none

module toroidal_life_grid_engine import tlge_pkg::*; #(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_opcode,
    input  wire logic [IDX_W-1:0] s_row_index,
    input  wire logic [IDX_W-1:0] s_column_index,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_cell_value
);

    localparam int RW = $clog2(GRID_ROWS);

    tlge_cmd_t    cmd;
    tlge_status_t status;
    logic [RW-1:0] rd_row, wr_row;

    tlge_ctrl #(
        .GRID_ROWS (GRID_ROWS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd),
        .rd_row   (rd_row),
        .wr_row   (wr_row)
    );

    tlge_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .cmd            (cmd),
        .rd_row         (rd_row),
        .wr_row         (wr_row),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_value   (m_cell_value)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tlge_checker.sv -----
// Port-level checker of the toroidal life grid engine and its bind.
`default_nettype none

`include "toroidal_life_grid_engine_assert.svh"

module tlge_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready
);

    `TLGE_ASSERT(a_m_valid_hold, (m_valid && !m_ready) |=> m_valid, "m_valid dropped before the word was taken")

    `TLGE_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> (!m_valid && !s_ready), "ports not quiet after reset")

    `TLGE_ASSERT_ALWAYS(a_init_sweep, $rose(aresetn) |=> !s_ready, "input taken during the reset sweep")

    `TLGE_ASSERT(a_one_in_work, (s_valid && s_ready) |=> !s_ready, "second word taken while one is in work")

    `TLGE_ASSERT(a_result_after_work, $rose(m_valid) |-> $past(!s_ready), "result appeared while the engine was idle")

endmodule

bind toroidal_life_grid_engine tlge_checker u_tlge_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

`default_nettype wire

// ----- verif/life_grid_checker.sv -----
`timescale 1ns / 1ps
// Life grid checker: keeps its own copy of the torus, predicts every result word and compares.
module life_grid_checker import tlge_pkg::*; #(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire logic [1:0]       s_opcode,
    input  wire logic [IDX_W-1:0] s_row_index,
    input  wire logic [IDX_W-1:0] s_column_index,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire logic             m_cell_value,
    output int                    mismatch_count,
    output int                    words_pending
);

    typedef struct {
        opcode_t          op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             value;
    } cell_forecast_t;

    bit [GRID_COLS-1:0] live_rows [GRID_ROWS];
    cell_forecast_t     cell_forecasts [$];

    function automatic void clear_grid();
        foreach (live_rows[r]) live_rows[r] = '0;
    endfunction

    // Apply one command to the grid copy and return the expected cell value.
    function automatic logic apply_command(opcode_t op, int r, int c);
        bit [GRID_COLS-1:0] nxt [GRID_ROWS];
        int   up, dn, lf, rt, n;
        logic on_grid;
        logic value;
        on_grid = (r < GRID_ROWS) && (c < GRID_COLS);
        value   = 1'b0;
        case (op)
            OP_STEP: begin
                for (int y = 0; y < GRID_ROWS; y++) begin
                    up = (y + GRID_ROWS - 1) % GRID_ROWS;
                    dn = (y + 1) % GRID_ROWS;
                    for (int x = 0; x < GRID_COLS; x++) begin
                        lf = (x + GRID_COLS - 1) % GRID_COLS;
                        rt = (x + 1) % GRID_COLS;
                        n  = int'(live_rows[up][lf]) + int'(live_rows[up][x])
                           + int'(live_rows[up][rt]) + int'(live_rows[y][lf])
                           + int'(live_rows[y][rt]) + int'(live_rows[dn][lf])
                           + int'(live_rows[dn][x]) + int'(live_rows[dn][rt]);
                        nxt[y][x] = (n == int'(LIFE_BIRTH)) ||
                                    (live_rows[y][x] && n == int'(LIFE_SURVIVE));
                    end
                end
                // swap in the whole generation at once
                foreach (live_rows[y]) live_rows[y] = nxt[y];
            end
            OP_TOGGLE: begin
                if (on_grid) begin
                    live_rows[r][c] = ~live_rows[r][c];
                    value = live_rows[r][c];
                end
            end
            OP_CLEAR: clear_grid();
            default: begin
                if (on_grid) value = live_rows[r][c];
            end
        endcase
        return value;
    endfunction

    task automatic report_mismatch(string what, string expected, logic actual);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s expected %s got %b", $realtime, what, expected, actual);
    endtask

    always @(posedge aclk) begin : watch
        cell_forecast_t fc;
        if (!aresetn) begin
            clear_grid();
            cell_forecasts.delete();
            words_pending <= 0;
        end else begin
            // a result word always trails its own command, so pop first
            if (m_valid && m_ready) begin
                if (cell_forecasts.size() == 0) begin
                    report_mismatch("result word with nothing pending", "none", m_cell_value);
                end else begin
                    fc = cell_forecasts.pop_front();
                    if (m_cell_value !== fc.value)
                        report_mismatch($sformatf("%s row %0d col %0d cell_value",
                                        fc.op.name(), fc.row, fc.col),
                                        $sformatf("%b", fc.value), m_cell_value);
                end
            end
            if (s_valid && s_ready) begin
                fc.op    = opcode_t'(s_opcode);
                fc.row   = s_row_index;
                fc.col   = s_column_index;
                fc.value = apply_command(fc.op, int'(s_row_index), int'(s_column_index));
                cell_forecasts.push_back(fc);
            end
            words_pending <= cell_forecasts.size();
        end
    end

endmodule

// ----- verif/tb_toroidal_life_grid_engine.sv -----
`timescale 1ns / 1ps
// Testbench top of the toroidal life grid engine: command stimulus, idling and verdict.
module tb_toroidal_life_grid_engine;
    import tlge_pkg::*;

    localparam int GRID_ROWS    = DEF_GRID_ROWS;
    localparam int GRID_COLS    = DEF_GRID_COLS;
    localparam int IDLE_PCT     = 17;
    localparam int RANDOM_WORDS = 115;
    localparam int CYCLE_LIMIT  = 200000;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_opcode;
    logic [IDX_W-1:0] s_row_index;
    logic [IDX_W-1:0] s_column_index;
    logic             m_valid;
    logic             m_ready;
    logic             m_cell_value;

    bit steady_run;
    int cycle_count;
    int mismatch_count;
    int words_pending;

    toroidal_life_grid_engine #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_value   (m_cell_value)
    );

    life_grid_checker #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_value   (m_cell_value),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Valid stays high from one word to the next unless an idle cycle drops it.
    task automatic send_word(opcode_t op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_row_index    <= r;
        s_column_index <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Pick a coordinate within two cells of a center; 6-bit arithmetic wraps the torus.
    function automatic logic [IDX_W-1:0] near_index(logic [IDX_W-1:0] ctr);
        return ctr + IDX_W'($urandom_range(0, 4)) - IDX_W'(2);
    endfunction

    initial begin
        logic [IDX_W-1:0] ctr_r, ctr_c;
        int               sent_random;
        s_valid        <= 1'b0;
        s_opcode       <= OP_STEP;
        s_row_index    <= '0;
        s_column_index <= '0;
        m_ready        <= 1'b0;
        aresetn        <= 1'b0;
        steady_run     <= 1'b0;
        cycle_count    <= 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty corners, then a 2x2 block split over all four corners
        send_word(OP_READ,   6'd0,  6'd0);
        send_word(OP_READ,   6'd63, 6'd63);
        send_word(OP_TOGGLE, 6'd0,  6'd0);
        send_word(OP_TOGGLE, 6'd0,  6'd63);
        send_word(OP_TOGGLE, 6'd63, 6'd0);
        send_word(OP_TOGGLE, 6'd63, 6'd63);
        send_word(OP_STEP,   6'h2A, 6'h15);
        send_word(OP_READ,   6'd63, 6'd0);
        send_word(OP_READ,   6'd1,  6'd1);
        // drop one corner: birth across both wraps restores the block
        send_word(OP_TOGGLE, 6'd63, 6'd63);
        send_word(OP_STEP,   6'd0,  6'd0);
        send_word(OP_READ,   6'd63, 6'd63);
        send_word(OP_CLEAR,  6'h3F, 6'h3F);
        send_word(OP_READ,   6'd0,  6'd0);
        // blinker crossing the right edge
        send_word(OP_TOGGLE, 6'd32, 6'd62);
        send_word(OP_TOGGLE, 6'd32, 6'd63);
        send_word(OP_TOGGLE, 6'd32, 6'd0);
        send_word(OP_STEP,   6'h15, 6'h2A);
        send_word(OP_READ,   6'd31, 6'd63);
        send_word(OP_READ,   6'd32, 6'd0);
        send_word(OP_TOGGLE, 6'h15, 6'h2A);
        send_word(OP_READ,   6'h2A, 6'h15);
        send_word(OP_STEP,   6'h3F, 6'h00);
        send_word(OP_READ,   6'd32, 6'd62);
        send_word(OP_CLEAR,  6'h00, 6'h3F);

        // seed a small patch, evolve it a few generations, read around it
        sent_random = 0;
        while (sent_random < RANDOM_WORDS) begin
            steady_run <= (sent_random >= 60 && sent_random < 95);
            if ($urandom_range(0, 3) == 0) begin
                send_word(OP_CLEAR, IDX_W'($urandom), IDX_W'($urandom));
                sent_random++;
            end
            ctr_r = ($urandom_range(0, 3) == 0) ? 6'd63 : IDX_W'($urandom);
            ctr_c = ($urandom_range(0, 3) == 0) ? 6'd0  : IDX_W'($urandom);
            repeat ($urandom_range(4, 10)) begin
                send_word(OP_TOGGLE, near_index(ctr_r), near_index(ctr_c));
                sent_random++;
            end
            repeat ($urandom_range(1, 4)) begin
                send_word(OP_STEP, IDX_W'($urandom), IDX_W'($urandom));
                sent_random++;
                repeat ($urandom_range(1, 3)) begin
                    send_word(OP_READ, near_index(ctr_r), near_index(ctr_c));
                    sent_random++;
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                send_word(opcode_t'($urandom_range(0, 3)), IDX_W'($urandom), IDX_W'($urandom));
                sent_random++;
            end
        end
        s_valid    <= 1'b0;
        steady_run <= 1'b0;

        do @(posedge aclk); while (words_pending != 0);
        repeat (GRID_ROWS + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
